// File: hdl/assert_macros.svh
// Assertion macros shared by the top2 expert gate modules.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define T2G_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define T2G_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/t2g_pkg.sv
// Types and constants of the top2 expert gate.
// No dependencies; the gate modules refer to it by scoped names.
package t2g_pkg;

	localparam int LOGIT_W   = 16;
	localparam int IDX_OUT_W = 6;
	localparam int WEIGHT_W  = 16;
	localparam int DIFF_W    = 12;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;

	// Series terms of exp(-d/4096), squared up to exp(-d/256).
	localparam logic [3:0] NUM_TERMS   = 4'd13;
	localparam logic [1:0] LAST_SQUARE = 2'd3;
	localparam logic [2:0] LAST_DIV_CYC = 3'd7;
	localparam logic [3:0] LAST_QBIT   = 4'd15;

	localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
	localparam logic [63:0] Q31_HALF = 64'h0000_0000_4000_0000;

	localparam int JOB_FIFO_DEPTH = 2;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic                      is_last;
	} logit_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] first_expert;
		logic [IDX_OUT_W-1:0] second_expert;
		logic [WEIGHT_W-1:0]  first_weight;
		logic [WEIGHT_W-1:0]  second_weight;
	} gate_item_t;

	// One finished token as handed from the tracker to the weight unit.
	typedef struct packed {
		logic [IDX_OUT_W-1:0] first_expert;
		logic [IDX_OUT_W-1:0] second_expert;
		logic                 saturate;
		logic [DIFF_W-1:0]    diff;
	} gate_job_t;

	typedef enum logic [3:0] {
		WU_IDLE,
		WU_TERM_MUL,
		WU_TERM_DIV,
		WU_TERM_ACC,
		WU_CLAMP,
		WU_SQ_MUL,
		WU_SQ_RND,
		WU_FDIV_SETUP,
		WU_FDIV,
		WU_OUT
	} wu_state_t;

endpackage

// File: hdl/t2g_stream_if.sv
// Valid/ready channel carrying one payload of a parameterized type.
// Depends on nothing; payload types come from t2g_pkg at instantiation.
interface t2g_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/t2g_tracker.sv
// Front end: tracks best and second-best logit of a token, emits a job on the last one.
// Depends on t2g_pkg, t2g_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module t2g_tracker #(
	parameter int MAX_EXPERTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	t2g_stream_if.sink     logits,
	t2g_stream_if.source   jobs
);
	localparam int IDX_W = $clog2(MAX_EXPERTS);
	localparam int CNT_W = $clog2(MAX_EXPERTS + 1);

	logic signed [t2g_pkg::LOGIT_W-1:0] best_q, second_q;
	logic [IDX_W-1:0] best_idx_q, second_idx_q;
	logic             have_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [t2g_pkg::LOGIT_W-1:0] best_n, second_n, v;
	logic [IDX_W-1:0] best_idx_n, second_idx_n, e;
	logic             have_n, in_range, acc;
	logic [CNT_W-1:0] cnt_n;
	logic signed [t2g_pkg::LOGIT_W:0] diff_full;
	t2g_pkg::gate_job_t job;

	assign v        = logits.data.logit;
	assign acc      = logits.valid && logits.ready;
	assign in_range = cnt_q < CNT_W'(MAX_EXPERTS);
	assign e        = cnt_q[IDX_W-1:0];

	always_comb begin
		best_n       = best_q;
		second_n     = second_q;
		best_idx_n   = best_idx_q;
		second_idx_n = second_idx_q;
		have_n       = have_q;
		cnt_n        = cnt_q;
		if (in_range) begin
			if (cnt_q == '0) begin
				best_n       = v;
				best_idx_n   = e;
				second_idx_n = '0;
			end else if (v > best_q) begin
				second_n     = best_q;
				second_idx_n = best_idx_q;
				have_n       = 1'b1;
				best_n       = v;
				best_idx_n   = e;
			end else if (!have_q || v > second_q) begin
				second_n     = v;
				second_idx_n = e;
				have_n       = 1'b1;
			end
			cnt_n = CNT_W'(cnt_q + 1'b1);
		end
	end

	// Equal values give a zero difference; with a second logit held it is never negative.
	assign diff_full = {best_n[t2g_pkg::LOGIT_W-1], best_n}
		- {second_n[t2g_pkg::LOGIT_W-1], second_n};

	always_comb begin
		job.first_expert  = t2g_pkg::IDX_OUT_W'(best_idx_n);
		job.second_expert = t2g_pkg::IDX_OUT_W'(second_idx_n);
		job.saturate      = !have_n || (diff_full[t2g_pkg::LOGIT_W:t2g_pkg::DIFF_W] != '0);
		job.diff          = diff_full[t2g_pkg::DIFF_W-1:0];
	end

	assign logits.ready = jobs.ready;
	assign jobs.valid   = logits.valid && logits.data.is_last;
	assign jobs.data    = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			have_q       <= 1'b0;
			best_idx_q   <= '0;
			second_idx_q <= '0;
		end else if (acc) begin
			if (logits.data.is_last) begin
				cnt_q        <= '0;
				have_q       <= 1'b0;
				best_idx_q   <= '0;
				second_idx_q <= '0;
			end else begin
				cnt_q        <= cnt_n;
				have_q       <= have_n;
				best_idx_q   <= best_idx_n;
				second_idx_q <= second_idx_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !logits.data.is_last) begin
			best_q   <= best_n;
			second_q <= second_n;
		end
	end

	`T2G_ASSERT_IMPL(a_have_second_count, have_q, cnt_q >= CNT_W'(2),
		"second logit flagged with fewer than two logits seen")

endmodule

// File: hdl/t2g_job_fifo.sv
// Short job queue between the tracker and the weight unit.
// Depends on t2g_pkg, t2g_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module t2g_job_fifo (
	input  logic         clk,
	input  logic         arst_n,
	t2g_stream_if.sink   in,
	t2g_stream_if.source out
);
	localparam int DEPTH = t2g_pkg::JOB_FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	t2g_pkg::gate_job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign in.ready  = count_q != CNT_W'(DEPTH);
	assign out.valid = count_q != '0;
	assign out.data  = entry_q[rp_q];
	assign push      = in.valid && in.ready;
	assign pop       = out.valid && out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp_q + 1'b1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= in.data;
		end
	end

	`T2G_ASSERT_NEXT(a_fifo_fill, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1),
		"queue occupancy did not grow on a lone push")

endmodule

// File: hdl/t2g_weight_unit.sv
// Back end: turns a job into two-way softmax weights with a shared multiplier,
// a radix-16 divider by the term index and a bit-serial final divider.
// Depends on t2g_pkg, t2g_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module t2g_weight_unit (
	input  logic         clk,
	input  logic         arst_n,
	t2g_stream_if.sink   jobs,
	t2g_stream_if.source gates
);
	t2g_pkg::wu_state_t state_q, state_n;

	logic [t2g_pkg::IDX_OUT_W-1:0] first_q, second_q;
	logic [t2g_pkg::DIFF_W-1:0]    d_q;
	logic [31:0]        t_q;
	logic signed [33:0] s_q;
	logic [3:0]         k_q;
	logic [2:0]         dcnt_q;
	logic [63:0]        prod_q;
	logic [31:0]        div_q;
	logic [3:0]         rem_q;
	logic [31:0]        e_q;
	logic [1:0]         sqc_q;
	logic [32:0]        den_q;
	logic [32:0]        frem_q;
	logic [15:0]        fq_q;
	logic [3:0]         fcnt_q;

	logic        job_acc, out_acc;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [31:0] div_n;
	logic [3:0]  rem_n;
	logic [32:0] den_n;
	logic [47:0] num_n;
	logic [33:0] fr_shift;
	logic        fq_bit;
	logic [32:0] frem_n;

	assign job_acc = jobs.valid && jobs.ready;
	assign out_acc = gates.valid && gates.ready;

	// Shared multiplier: series term t*d or squaring e*e.
	assign mul_a = (state_q == t2g_pkg::WU_SQ_MUL) ? e_q : t_q;
	assign mul_b = (state_q == t2g_pkg::WU_SQ_MUL) ? e_q : 32'(d_q);
	assign mul_p = mul_a * mul_b;

	// Four quotient bits per cycle of (t*d >> 12) / k.
	always_comb begin
		logic [31:0] src;
		logic [3:0]  r;
		logic [4:0]  r5;
		src = (dcnt_q == '0) ? prod_q[43:12] : div_q;
		r   = (dcnt_q == '0) ? 4'd0 : rem_q;
		for (int i = 0; i < 4; i++) begin
			r5  = {r, src[31]};
			src = {src[30:0], 1'b0};
			if (r5 >= {1'b0, k_q}) begin
				r      = 4'(r5 - {1'b0, k_q});
				src[0] = 1'b1;
			end else begin
				r = r5[3:0];
			end
		end
		div_n = src;
		rem_n = r;
	end

	assign den_n = {1'b0, t2g_pkg::Q31_ONE} + {1'b0, e_q};
	assign num_n = (48'(16'hFFFF) << 31) + 48'(den_n >> 1);

	assign fr_shift = {frem_q, fq_q[15]};
	assign fq_bit   = fr_shift >= {1'b0, den_q};
	assign frem_n   = fq_bit ? 33'(fr_shift - {1'b0, den_q}) : fr_shift[32:0];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			t2g_pkg::WU_IDLE: begin
				if (job_acc) begin
					state_n = jobs.data.saturate ? t2g_pkg::WU_OUT : t2g_pkg::WU_TERM_MUL;
				end
			end
			t2g_pkg::WU_TERM_MUL: state_n = t2g_pkg::WU_TERM_DIV;
			t2g_pkg::WU_TERM_DIV: begin
				if (dcnt_q == t2g_pkg::LAST_DIV_CYC) begin
					state_n = t2g_pkg::WU_TERM_ACC;
				end
			end
			t2g_pkg::WU_TERM_ACC: begin
				state_n = (k_q == t2g_pkg::NUM_TERMS) ? t2g_pkg::WU_CLAMP
					: t2g_pkg::WU_TERM_MUL;
			end
			t2g_pkg::WU_CLAMP:  state_n = t2g_pkg::WU_SQ_MUL;
			t2g_pkg::WU_SQ_MUL: state_n = t2g_pkg::WU_SQ_RND;
			t2g_pkg::WU_SQ_RND: begin
				state_n = (sqc_q == t2g_pkg::LAST_SQUARE) ? t2g_pkg::WU_FDIV_SETUP
					: t2g_pkg::WU_SQ_MUL;
			end
			t2g_pkg::WU_FDIV_SETUP: state_n = t2g_pkg::WU_FDIV;
			t2g_pkg::WU_FDIV: begin
				if (fcnt_q == t2g_pkg::LAST_QBIT) begin
					state_n = t2g_pkg::WU_OUT;
				end
			end
			t2g_pkg::WU_OUT: begin
				if (out_acc) begin
					state_n = t2g_pkg::WU_IDLE;
				end
			end
			default: state_n = t2g_pkg::WU_IDLE;
		endcase
	end

	always_comb begin
		jobs.ready               = state_q == t2g_pkg::WU_IDLE;
		gates.valid              = state_q == t2g_pkg::WU_OUT;
		gates.data.first_expert  = first_q;
		gates.data.second_expert = second_q;
		gates.data.first_weight  = fq_q;
		gates.data.second_weight = t2g_pkg::WEIGHT_MAX - fq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= t2g_pkg::WU_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			t2g_pkg::WU_IDLE: begin
				if (job_acc) begin
					first_q  <= jobs.data.first_expert;
					second_q <= jobs.data.second_expert;
					d_q      <= jobs.data.diff;
					t_q      <= t2g_pkg::Q31_ONE;
					s_q      <= 34'(t2g_pkg::Q31_ONE);
					k_q      <= 4'd1;
					fq_q     <= t2g_pkg::WEIGHT_MAX;
				end
			end
			t2g_pkg::WU_TERM_MUL: begin
				prod_q <= mul_p;
				dcnt_q <= '0;
			end
			t2g_pkg::WU_TERM_DIV: begin
				div_q  <= div_n;
				rem_q  <= rem_n;
				dcnt_q <= 3'(dcnt_q + 1'b1);
			end
			t2g_pkg::WU_TERM_ACC: begin
				t_q <= div_q;
				// Alternating series: odd terms subtract, even terms add.
				if (k_q[0]) begin
					s_q <= s_q - $signed({2'b00, div_q});
				end else begin
					s_q <= s_q + $signed({2'b00, div_q});
				end
				k_q <= 4'(k_q + 1'b1);
			end
			t2g_pkg::WU_CLAMP: begin
				if (s_q < 0) begin
					e_q <= '0;
				end else if (s_q > $signed(34'(t2g_pkg::Q31_ONE))) begin
					e_q <= t2g_pkg::Q31_ONE;
				end else begin
					e_q <= s_q[31:0];
				end
				sqc_q <= '0;
			end
			t2g_pkg::WU_SQ_MUL: begin
				prod_q <= mul_p;
			end
			t2g_pkg::WU_SQ_RND: begin
				e_q   <= 32'((prod_q + t2g_pkg::Q31_HALF) >> 31);
				sqc_q <= 2'(sqc_q + 1'b1);
			end
			t2g_pkg::WU_FDIV_SETUP: begin
				den_q  <= den_n;
				frem_q <= {1'b0, num_n[47:16]};
				fq_q   <= num_n[15:0];
				fcnt_q <= '0;
			end
			t2g_pkg::WU_FDIV: begin
				frem_q <= frem_n;
				fq_q   <= {fq_q[14:0], fq_bit};
				fcnt_q <= 4'(fcnt_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	`T2G_ASSERT_IMPL(a_fdiv_rem_bound, state_q == t2g_pkg::WU_FDIV, frem_q < den_q,
		"final divider remainder not below the divisor")
	`T2G_ASSERT_IMPL(a_term_index, state_q == t2g_pkg::WU_TERM_ACC,
		k_q >= 4'd1 && k_q <= t2g_pkg::NUM_TERMS, "series term index out of range")

endmodule

// File: hdl/top2_expert_gate_unit.sv
// Channel    | Dir  | Payload                                         | Transaction
// logits     | in   | logit (s16, Q7.8), is_last                       | valid && ready
// gates      | out  | first/second_expert (u6), first/second_weight    | valid && ready
//
// The tracker takes one logit per cycle while the job queue has room.
// A token whose logits differ by 16.0 or more, or that has one logit, yields its
// result in the cycle after it leaves the queue; otherwise the weight unit works
// through 13 series terms, four squarings and a bit-serial final divider.
// Reset is asynchronous and active low and clears tracker, queue and FSM control.
// A stalled result holds the weight unit; the tracker runs on until the queue fills.
//
// Top level of the top-2 expert gate; depends on t2g_pkg, t2g_stream_if,
// t2g_tracker, t2g_job_fifo and t2g_weight_unit.
module top2_expert_gate_unit #(
	parameter int MAX_EXPERTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	t2g_stream_if.sink   logits,
	t2g_stream_if.source gates
);
	t2g_stream_if #(.payload_t(t2g_pkg::gate_job_t)) push_if ();
	t2g_stream_if #(.payload_t(t2g_pkg::gate_job_t)) pop_if ();

	t2g_tracker #(
		.MAX_EXPERTS(MAX_EXPERTS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.logits (logits),
		.jobs   (push_if)
	);

	t2g_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (push_if),
		.out    (pop_if)
	);

	t2g_weight_unit u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.jobs   (pop_if),
		.gates  (gates)
	);

endmodule
